>>> design/dmac_pkg.sv
package dmac_pkg;

  localparam int DefChannels = 4;

  typedef enum logic [2:0] {
    MODE_REG_WR  = 3'd0,
    MODE_REG_RD  = 3'd1,
    MODE_PAGE_WR = 3'd2,
    MODE_PAGE_RD = 3'd3,
    MODE_XFER    = 3'd4
  } mode_code_t;

  localparam logic [3:0] REG_STATUS     = 4'd8;
  localparam logic [3:0] REG_MASK_ONE   = 4'd10;
  localparam logic [3:0] REG_MODE       = 4'd11;
  localparam logic [3:0] REG_CLR_FF     = 4'd12;
  localparam logic [3:0] REG_MASTER_CLR = 4'd13;
  localparam logic [3:0] REG_CLR_MASK   = 4'd14;
  localparam logic [3:0] REG_MULTI_MASK = 4'd15;

  localparam logic [1:0] CFG_WRAP_MASK = 2'd0;
  localparam logic [1:0] CFG_WIDE      = 2'd1;
  localparam logic [1:0] CFG_REQUEST   = 2'd2;

  typedef struct packed {
    logic [2:0]  mode;
    logic [3:0]  register_index;
    logic [7:0]  write_data;
    logic [1:0]  channel;
    logic [15:0] word_count;
  } in_item_t;

  typedef struct packed {
    logic [15:0] read_data;
    logic [15:0] words_done;
    logic        reached_terminal;
    logic [23:0] start_address;
    logic        channel_masked;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // capture item, execute register and page work, start transfer
    logic div_step; // one remainder iteration
    logic finish;   // commit transfer result
  } dp_cmd_t;

  typedef struct packed {
    logic div_busy;
  } dp_sts_t;

endpackage

>>> design/dmac_ctrl.sv
module dmac_ctrl
  import dmac_pkg::*;
(
  input  logic    clk,
  input  logic    rst_n,
  input  logic    in_valid,
  output logic    in_ready,
  output logic    out_valid,
  input  logic    out_ready,
  input  dp_sts_t sts,
  output dp_cmd_t cmd
);

  typedef enum logic [1:0] {S_IDLE, S_WORK, S_OUT} state_t;

  state_t state_r, state_nxt;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt    = state_r;
    cmd          = '0;
    cmd.load     = in_valid && in_ready;
    case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_WORK;
      end
      S_WORK: begin
        if (sts.div_busy) begin
          cmd.div_step = 1'b1;
        end else begin
          cmd.finish = 1'b1;
          state_nxt  = S_OUT;
        end
      end
      S_OUT: begin
        if (out_ready) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

`ifndef SYNTH
  a_out_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r) == S_WORK) else $error("out without work");
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("accept while result pending");
  a_finish_once: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> !cmd.finish) else $error("double finish");
`endif

endmodule

>>> design/dmac_datapath.sv
module dmac_datapath
  import dmac_pkg::*;
#(
  parameter int CHANNELS = DefChannels
) (
  input  logic        clk,
  input  logic        rst_n,
  input  in_item_t    in_item,
  input  dp_cmd_t     cmd,
  output dp_sts_t     sts,
  output out_item_t   out_item,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  localparam int CW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  logic [15:0] base_addr_r [CHANNELS];
  logic [15:0] cur_addr_r  [CHANNELS];
  logic [15:0] base_cnt_r  [CHANNELS];
  logic [15:0] cur_cnt_r   [CHANNELS];
  logic [7:0]  page_r      [CHANNELS];
  logic [CHANNELS-1:0] auto_r, incr_r, mask_r, tc_r;
  logic ff_r;
  logic [15:0] wrap_r;
  logic wide_r;
  logic [3:0] req_r;

  // Transfer work registers.
  logic xfer_r;          // auto-init reload pending commit
  logic [CW-1:0] xch_r;
  logic xok_r;
  logic [16:0] rem_r;     // remainder being reduced
  logic [16:0] period_r;
  logic [4:0] bit_r;
  logic busy_r;
  out_item_t res_r;

  logic [3:0] ch_ext;
  logic ch_ok;
  logic [CW-1:0] ch;
  logic [3:0] rch_ext;
  logic rch_ok;
  logic [CW-1:0] rch;
  logic [CW-1:0] dch;
  logic [3:0] dch_ext;
  logic dch_ok;
  logic ff_new;
  logic [15:0] rval;
  logic [15:0] amask;
  logic [16:0] left;
  logic [16:0] want;
  logic [16:0] extra;
  logic [23:0] pbase;
  logic [33:0] trial;
  logic [7:0] stat;
  out_item_t res_ld;
  logic xfer_ld;

  assign ch_ext  = {2'b0, in_item.channel};
  assign ch_ok   = ch_ext < 4'(CHANNELS);
  assign ch      = CW'(in_item.channel);
  assign rch_ext = {2'b0, in_item.register_index[2:1]};
  assign rch_ok  = rch_ext < 4'(CHANNELS);
  assign rch     = CW'(in_item.register_index[2:1]);
  assign dch_ext = {2'b0, in_item.write_data[1:0]};
  assign dch_ok  = dch_ext < 4'(CHANNELS);
  assign dch     = CW'(in_item.write_data[1:0]);
  assign ff_new  = ~ff_r;
  assign rval    = in_item.register_index[0] ? cur_cnt_r[rch] : cur_addr_r[rch];
  assign amask   = cur_addr_r[ch] & wrap_r;
  assign left    = {1'b0, cur_cnt_r[ch]} + 17'd1;
  assign want    = {1'b0, in_item.word_count};
  assign extra   = want - left;
  assign pbase   = wide_r ? {page_r[ch][7:1], 17'd0} : {page_r[ch], 16'd0};
  // Restoring remainder: one quotient bit per cycle, high bit first.
  assign trial   = {17'd0, period_r} << bit_r;
  assign sts.div_busy = busy_r;
  assign out_item = res_r;

  always_comb begin
    stat = '0;
    for (int c = 0; c < 4; c++) begin
      if (c < CHANNELS) begin
        stat[c]   = tc_r[c];
        stat[4+c] = req_r[c];
      end
    end
  end

  // Result fields known at load time; the mask bit is added on finish.
  always_comb begin
    res_ld  = '0;
    xfer_ld = 1'b0;
    case (in_item.mode)
      MODE_REG_RD: begin
        if (in_item.register_index < 4'd8) begin
          if (rch_ok) begin
            res_ld.read_data = ff_new ? {8'd0, rval[7:0]} : {8'd0, rval[15:8]};
          end else begin
            res_ld.read_data = 16'hffff;
          end
        end else if (in_item.register_index == REG_STATUS) begin
          res_ld.read_data = {8'd0, stat};
        end else begin
          res_ld.read_data = 16'hffff;
        end
      end
      MODE_PAGE_RD: if (ch_ok) res_ld.read_data = {8'd0, page_r[ch]};
      MODE_XFER: begin
        if (ch_ok) begin
          res_ld.start_address = pbase + (wide_r ? {7'd0, amask, 1'b0} : {8'd0, amask});
          if (want < left) begin
            res_ld.words_done = in_item.word_count;
          end else begin
            res_ld.reached_terminal = 1'b1;
            if (auto_r[ch]) begin
              res_ld.words_done = in_item.word_count;
              xfer_ld = 1'b1;
            end else begin
              res_ld.words_done = left[15:0];
            end
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int c = 0; c < CHANNELS; c++) begin
        base_addr_r[c] <= '0;
        cur_addr_r[c]  <= '0;
        base_cnt_r[c]  <= '0;
        cur_cnt_r[c]   <= '0;
        page_r[c]      <= '0;
      end
      auto_r <= '0;
      incr_r <= '1;
      mask_r <= '1;
      tc_r   <= '0;
      ff_r   <= 1'b0;
      wrap_r <= 16'hffff;
      wide_r <= 1'b0;
      req_r  <= '0;
      busy_r <= 1'b0;
      xfer_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_WRAP_MASK: wrap_r <= cfg_wdata;
          CFG_WIDE:      wide_r <= cfg_wdata[0];
          CFG_REQUEST:   req_r  <= cfg_wdata[3:0];
          default: ;
        endcase
      end
      if (cmd.load) begin
        res_r  <= res_ld;
        xfer_r <= xfer_ld;
        xch_r  <= ch;
        xok_r  <= ch_ok;
        case (in_item.mode)
          MODE_REG_WR: begin
            if (in_item.register_index < 4'd8) begin
              if (rch_ok) begin
                ff_r <= ff_new;
                if (in_item.register_index[0]) begin
                  if (ff_new) begin
                    base_cnt_r[rch][7:0] <= in_item.write_data;
                    cur_cnt_r[rch][7:0]  <= in_item.write_data;
                  end else begin
                    base_cnt_r[rch][15:8] <= in_item.write_data;
                    cur_cnt_r[rch][15:8]  <= in_item.write_data;
                  end
                end else begin
                  if (ff_new) begin
                    base_addr_r[rch][7:0] <= in_item.write_data;
                    cur_addr_r[rch][7:0]  <= in_item.write_data;
                  end else begin
                    base_addr_r[rch][15:8] <= in_item.write_data;
                    cur_addr_r[rch][15:8]  <= in_item.write_data;
                  end
                end
              end
            end else begin
              case (in_item.register_index)
                REG_MASK_ONE: if (dch_ok) mask_r[dch] <= in_item.write_data[2];
                REG_MODE: begin
                  if (dch_ok) begin
                    auto_r[dch] <= in_item.write_data[4];
                    incr_r[dch] <= in_item.write_data[5];
                  end
                end
                REG_CLR_FF: ff_r <= 1'b0;
                REG_MASTER_CLR: begin
                  mask_r <= '1;
                  tc_r   <= '0;
                  ff_r   <= 1'b0;
                end
                REG_CLR_MASK: mask_r <= '0;
                REG_MULTI_MASK: begin
                  for (int c = 0; c < CHANNELS; c++) mask_r[c] <= in_item.write_data[c];
                end
                default: ;
              endcase
            end
          end
          MODE_REG_RD: begin
            if (in_item.register_index < 4'd8) begin
              if (rch_ok) ff_r <= ff_new;
            end else if (in_item.register_index == REG_STATUS) begin
              tc_r <= '0;
            end
          end
          MODE_PAGE_WR: if (ch_ok) page_r[ch] <= in_item.write_data;
          MODE_XFER: begin
            if (ch_ok) begin
              if (want < left) begin
                cur_addr_r[ch] <= amask + in_item.word_count;
                cur_cnt_r[ch]  <= cur_cnt_r[ch] - in_item.word_count;
              end else begin
                tc_r[ch] <= 1'b1;
                if (auto_r[ch]) begin
                  rem_r    <= extra;
                  period_r <= {1'b0, base_cnt_r[ch]} + 17'd1;
                  bit_r    <= 5'd16;
                  busy_r   <= 1'b1;
                  cur_addr_r[ch] <= amask;
                end else begin
                  cur_addr_r[ch] <= amask + left[15:0];
                  cur_cnt_r[ch]  <= 16'hffff;
                  mask_r[ch]     <= 1'b1;
                end
              end
            end
          end
          default: ;
        endcase
      end
      if (cmd.div_step) begin
        if ({17'd0, rem_r} >= trial) rem_r <= rem_r - trial[16:0];
        if (bit_r == 5'd0) busy_r <= 1'b0;
        else bit_r <= bit_r - 5'd1;
      end
      if (cmd.finish) begin
        if (xfer_r) begin
          cur_addr_r[xch_r] <= base_addr_r[xch_r] + rem_r[15:0];
          cur_cnt_r[xch_r]  <= base_cnt_r[xch_r] - rem_r[15:0];
        end
        res_r.channel_masked <= xok_r ? mask_r[xch_r] : 1'b1;
      end
    end
  end

`ifndef SYNTH
  a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> rem_r < period_r) else $error("remainder not reduced");
  a_busy_xfer: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> xfer_r) else $error("divider busy without transfer");
  a_term_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy_r) |-> res_r.reached_terminal) else $error("reload without terminal");
`endif

endmodule

>>> design/dma_controller_channels_core.sv
// Each item is accepted in S_IDLE, processed in S_WORK and presented in S_OUT; an auto-init
// transfer that reaches terminal count stays in S_WORK while the bit-serial remainder unit
// runs. One item is in flight at a time: a new item is accepted only after the last result
// has been taken at the output.
// Reset: synchronous active-low rst_n restores all channel registers and config.
module dma_controller_channels_core
  import dmac_pkg::*;
#(
  parameter int CHANNELS = DefChannels
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  in_item_t    in_data,
  output logic        out_valid,
  input  logic        out_ready,
  output out_item_t   out_data,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata
);

  dp_cmd_t cmd;
  dp_sts_t sts;

  dmac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  dmac_datapath #(.CHANNELS(CHANNELS)) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_data),
    .cmd       (cmd),
    .sts       (sts),
    .out_item  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

endmodule

>>> verif/dma_controller_channels_core_tb.sv
`timescale 1ns / 100ps

module dma_controller_channels_core_tb;
  import dmac_pkg::*;

  localparam int NumChan = 4;
  localparam int IdleLimit = 20000;
  localparam int MaxErrShown = 10;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  in_item_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_item_t   out_data;
  logic        cfg_we;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;

  dma_controller_channels_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  // Shadow copy of the controller state.
  logic [15:0] sh_base_addr [NumChan];
  logic [15:0] sh_cur_addr [NumChan];
  logic [15:0] sh_base_cnt [NumChan];
  logic [15:0] sh_cur_cnt [NumChan];
  logic [7:0]  sh_page [NumChan];
  logic        sh_autoinit [NumChan];
  logic        sh_incr [NumChan];
  logic        sh_mask [NumChan];
  logic        sh_tc [NumChan];
  logic        sh_flipflop;
  logic [15:0] sh_wrap_mask;
  logic        sh_wide;
  logic [3:0]  sh_request;

  in_item_t  pending_beats [$];
  out_item_t expected_beats [$];
  int        mismatch_count;
  int        result_count;
  int        xfer_count;
  int        wrap_count;
  int        idle_cycles;
  logic      timed_out;
  logic      in_fire;

  function automatic logic [15:0] merge_byte(logic [15:0] old, logic [7:0] v, logic lo);
    return lo ? {old[15:8], v} : {v, old[7:0]};
  endfunction

  task automatic shadow_reset();
    for (int c = 0; c < NumChan; c++) begin
      sh_base_addr[c] = '0; sh_cur_addr[c] = '0; sh_base_cnt[c] = '0;
      sh_cur_cnt[c] = '0; sh_page[c] = '0; sh_autoinit[c] = 1'b0;
      sh_incr[c] = 1'b1; sh_mask[c] = 1'b1; sh_tc[c] = 1'b0;
    end
    sh_flipflop = 1'b0;
    sh_wrap_mask = 16'hffff;
    sh_wide = 1'b0;
    sh_request = 4'h0;
  endtask

  task automatic predict_channel_op(input in_item_t it, output out_item_t res);
    int c;
    logic [15:0] v;
    logic [7:0] d;
    logic [16:0] left;
    logic [16:0] period;
    logic [31:0] want;
    logic [31:0] rem;
    logic [31:0] done;
    logic [23:0] pg_origin;
    res = '0;
    c = it.channel;
    d = it.write_data;
    case (it.mode)
      MODE_REG_WR: begin
        if (it.register_index < 4'd8) begin
          sh_flipflop = ~sh_flipflop;
          if (!it.register_index[0]) begin
            sh_base_addr[it.register_index >> 1] =
              merge_byte(sh_base_addr[it.register_index >> 1], d, sh_flipflop);
            sh_cur_addr[it.register_index >> 1] =
              merge_byte(sh_cur_addr[it.register_index >> 1], d, sh_flipflop);
          end else begin
            sh_base_cnt[it.register_index >> 1] =
              merge_byte(sh_base_cnt[it.register_index >> 1], d, sh_flipflop);
            sh_cur_cnt[it.register_index >> 1] =
              merge_byte(sh_cur_cnt[it.register_index >> 1], d, sh_flipflop);
          end
        end else begin
          case (it.register_index)
            REG_MASK_ONE: sh_mask[d[1:0]] = d[2];
            REG_MODE: begin
              sh_autoinit[d[1:0]] = d[4];
              sh_incr[d[1:0]] = d[5];
            end
            REG_CLR_FF: sh_flipflop = 1'b0;
            REG_MASTER_CLR: begin
              for (int k = 0; k < NumChan; k++) begin
                sh_mask[k] = 1'b1;
                sh_tc[k] = 1'b0;
              end
              sh_flipflop = 1'b0;
            end
            REG_CLR_MASK: for (int k = 0; k < NumChan; k++) sh_mask[k] = 1'b0;
            REG_MULTI_MASK: for (int k = 0; k < NumChan; k++) sh_mask[k] = d[k];
            default: ;
          endcase
        end
      end
      MODE_REG_RD: begin
        if (it.register_index < 4'd8) begin
          sh_flipflop = ~sh_flipflop;
          v = it.register_index[0] ? sh_cur_cnt[it.register_index >> 1]
                                   : sh_cur_addr[it.register_index >> 1];
          res.read_data = sh_flipflop ? {8'h00, v[7:0]} : {8'h00, v[15:8]};
        end else if (it.register_index == REG_STATUS) begin
          for (int k = 0; k < NumChan; k++) begin
            res.read_data[k] = sh_tc[k];
            res.read_data[4 + k] = sh_request[k];
            sh_tc[k] = 1'b0;
          end
        end else begin
          res.read_data = 16'hffff;
        end
      end
      MODE_PAGE_WR: sh_page[c] = d;
      MODE_PAGE_RD: res.read_data = {8'h00, sh_page[c]};
      MODE_XFER: begin
        sh_cur_addr[c] = sh_cur_addr[c] & sh_wrap_mask;
        pg_origin = sh_wide ? {sh_page[c][7:1], 17'h0} : {sh_page[c], 16'h0};
        res.start_address = pg_origin + (24'(sh_cur_addr[c]) << sh_wide);
        want = 32'(it.word_count);
        left = 17'(sh_cur_cnt[c]) + 17'd1;
        if (want < 32'(left)) begin
          done = want;
          sh_cur_addr[c] = sh_cur_addr[c] + want[15:0];
          sh_cur_cnt[c] = sh_cur_cnt[c] - want[15:0];
        end else begin
          want = want - 32'(left);
          done = 32'(left);
          res.reached_terminal = 1'b1;
          sh_tc[c] = 1'b1;
          if (sh_autoinit[c]) begin
            period = 17'(sh_base_cnt[c]) + 17'd1;
            done = done + want;
            rem = want % 32'(period);
            sh_cur_addr[c] = sh_base_addr[c] + rem[15:0];
            sh_cur_cnt[c] = sh_base_cnt[c] - rem[15:0];
          end else begin
            sh_cur_addr[c] = sh_cur_addr[c] + left[15:0];
            sh_cur_cnt[c] = 16'hffff;
            sh_mask[c] = 1'b1;
          end
        end
        res.words_done = done[15:0];
      end
      default: ;
    endcase
    res.channel_masked = sh_mask[c];
  endtask

  function automatic in_item_t make_beat(mode_code_t m, logic [3:0] r, logic [7:0] d,
                                         logic [1:0] c, logic [15:0] w);
    in_item_t it;
    it.mode = m;
    it.register_index = r;
    it.write_data = d;
    it.channel = c;
    it.word_count = w;
    return it;
  endfunction

  function automatic in_item_t random_beat();
    in_item_t it;
    it.mode = 3'($urandom_range(0, 7));
    it.register_index = 4'($urandom);
    it.write_data = 8'($urandom);
    it.channel = 2'($urandom);
    case ($urandom_range(0, 3))
      0: it.word_count = 16'($urandom);
      1: it.word_count = 16'($urandom_range(0, 3));
      default: it.word_count = 16'($urandom_range(0, 40));
    endcase
    return it;
  endfunction

  // Program one channel (random address, mostly small count, mode, page, unmask), then transfer.
  task automatic queue_channel_program(int n_xfers);
    logic [1:0] c;
    c = 2'($urandom);
    pending_beats.push_back(make_beat(MODE_REG_WR, REG_CLR_FF, 8'h00, c, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, {1'b0, c, 1'b0}, 8'($urandom), c, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, {1'b0, c, 1'b0}, 8'($urandom), c, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, {1'b0, c, 1'b1},
                                      8'($urandom_range(0, 30)), c, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, {1'b0, c, 1'b1},
                                      ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'h00,
                                      c, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, REG_MODE,
                                      {2'($urandom), 1'($urandom), 3'($urandom), c},
                                      c, 16'h0));
    pending_beats.push_back(make_beat(MODE_PAGE_WR, 4'($urandom), 8'($urandom), c, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, REG_MASK_ONE,
                                      {5'($urandom), 1'b0, c}, c, 16'h0));
    for (int i = 0; i < n_xfers; i++)
      pending_beats.push_back(make_beat(MODE_XFER, 4'($urandom), 8'($urandom), c,
                                        ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                                                   : 16'($urandom_range(0, 70))));
    pending_beats.push_back(make_beat(MODE_REG_RD, REG_STATUS, 8'h00, c, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_RD, {1'b0, c, 1'($urandom)}, 8'h00, c, 16'h0));
  endtask

  task automatic wait_drained();
    while (pending_beats.size() != 0 || expected_beats.size() != 0 || in_valid)
      @(posedge clk);
    repeat (25) @(posedge clk);
  endtask

  task automatic write_setting(logic [1:0] idx, logic [15:0] val);
    @(negedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      CFG_WRAP_MASK: sh_wrap_mask = val;
      CFG_WIDE: sh_wide = val[0];
      default: sh_request = val[3:0];
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Remembers whether the last rising edge took the input beat.
  always @(posedge clk) begin
    in_fire <= rst_n && in_valid && in_ready;
  end

  // Sender: bursts of beats separated by random gaps.
  int burst_left;
  int gap_left;
  logic hold_off;

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      burst_left <= 0;
      gap_left <= 0;
    end else if (in_valid && !in_fire) begin
      // hold the beat until accepted
    end else if (gap_left > 0) begin
      in_valid <= 1'b0;
      gap_left <= gap_left - 1;
    end else if (pending_beats.size() != 0 && !hold_off) begin
      in_valid <= 1'b1;
      in_data <= pending_beats.pop_front();
      if (burst_left <= 1) begin
        burst_left <= $urandom_range(1, 20);
        gap_left <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      end else begin
        burst_left <= burst_left - 1;
      end
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Receiver stall pattern: long ready runs alternating with random stalls.
  int stall_phase;
  always @(negedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      stall_phase <= 0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase[8])
        out_ready <= 1'b1;
      else
        out_ready <= (stall_phase[2:0] != 3'd5) && ($urandom_range(0, 3) != 0);
    end
  end

  // Monitor: predict on input acceptance, check on output acceptance.
  always @(posedge clk) begin
    out_item_t exp_res;
    out_item_t got;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        predict_channel_op(in_data, exp_res);
        expected_beats.push_back(exp_res);
        if (in_data.mode == MODE_XFER) begin
          xfer_count++;
          if (exp_res.reached_terminal) wrap_count++;
        end
      end
      if (out_valid && out_ready) begin
        got = out_data;
        result_count++;
        if (expected_beats.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= MaxErrShown)
            $display("ERROR: unexpected result beat %p", got);
        end else begin
          exp_res = expected_beats.pop_front();
          if (got.read_data !== exp_res.read_data ||
              got.words_done !== exp_res.words_done ||
              got.reached_terminal !== exp_res.reached_terminal ||
              got.start_address !== exp_res.start_address ||
              got.channel_masked !== exp_res.channel_masked) begin
            mismatch_count++;
            if (mismatch_count <= MaxErrShown)
              $display("ERROR: result %0d expected %p got %p", result_count, exp_res, got);
          end
        end
      end
      if ((in_valid && in_ready) || (out_valid && out_ready))
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
    end
  end

  always @(posedge clk) begin
    if (idle_cycles >= IdleLimit && !timed_out) begin
      timed_out = 1'b1;
      $display("Timeout: no beat moved for %0d cycles", IdleLimit);
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = CFG_WRAP_MASK;
    cfg_wdata = '0;
    hold_off = 1'b0;
    mismatch_count = 0;
    result_count = 0;
    xfer_count = 0;
    wrap_count = 0;
    idle_cycles = 0;
    timed_out = 1'b0;
    shadow_reset();
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part: every mode, channel 0 registers, most command registers, field extremes.
    pending_beats.push_back(make_beat(MODE_REG_RD, REG_STATUS, 8'h00, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, 4'd0, 8'hff, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, 4'd0, 8'h80, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, 4'd1, 8'h03, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, 4'd1, 8'h00, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_RD, 4'd0, 8'h00, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_RD, 4'd0, 8'h00, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(MODE_PAGE_WR, 4'd0, 8'hff, 2'd3, 16'h0));
    pending_beats.push_back(make_beat(MODE_PAGE_RD, 4'd0, 8'h00, 2'd3, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, REG_MODE, 8'h10, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, REG_CLR_MASK, 8'h00, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(MODE_XFER, 4'd0, 8'h00, 2'd0, 16'hffff));
    pending_beats.push_back(make_beat(MODE_XFER, 4'd0, 8'h00, 2'd1, 16'h0000));
    pending_beats.push_back(make_beat(MODE_XFER, 4'd0, 8'h00, 2'd1, 16'h0001));
    pending_beats.push_back(make_beat(MODE_REG_RD, REG_STATUS, 8'h00, 2'd1, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, REG_MASK_ONE, 8'h06, 2'd2, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, REG_MULTI_MASK, 8'h0a, 2'd1, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, REG_MASTER_CLR, 8'h00, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, 4'd8, 8'h55, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_WR, 4'd9, 8'haa, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_RD, 4'd15, 8'h00, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(MODE_REG_RD, 4'd9, 8'h00, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(mode_code_t'(3'd5), 4'd0, 8'h00, 2'd0, 16'h0));
    pending_beats.push_back(make_beat(mode_code_t'(3'd7), 4'hf, 8'hff, 2'd3, 16'hffff));
    wait_drained();

    // Random phases, each under a different setting.
    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: begin
          write_setting(CFG_WRAP_MASK, 16'h0000);
          write_setting(CFG_WIDE, 16'h0001);
          write_setting(CFG_REQUEST, 16'h000f);
        end
        1: begin
          write_setting(CFG_WRAP_MASK, 16'hffff);
          write_setting(CFG_WIDE, 16'h0000);
          write_setting(CFG_REQUEST, 16'h0000);
        end
        default: begin
          write_setting(CFG_WRAP_MASK, 16'($urandom));
          write_setting(CFG_WIDE, 16'($urandom_range(0, 1)));
          write_setting(CFG_REQUEST, 16'($urandom_range(0, 15)));
        end
      endcase
      while (pending_beats.size() < 160) begin
        if ($urandom_range(0, 3) != 0)
          queue_channel_program($urandom_range(1, 6));
        else
          pending_beats.push_back(random_beat());
      end
      if (phase == 3) begin
        // Let the block drain completely before the next burst.
        hold_off = 1'b1;
        while (expected_beats.size() != 0 || in_valid) @(posedge clk);
        hold_off = 1'b0;
      end
      wait_drained();
    end

    $display("Ran %0d result beats, %0d transfers, %0d reaching terminal count,",
             result_count, xfer_count, wrap_count);
    $display("over six configuration settings including the field extremes.");
    if (mismatch_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
design/dmac_pkg.sv
design/dmac_ctrl.sv
design/dmac_datapath.sv
design/dma_controller_channels_core.sv
verif/dma_controller_channels_core_tb.sv
